// ===== hw/rtl/phototypesetter_command_encoder_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the phototypesetter command encoder
// Concurrent checks that vanish when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef PHOTOTYPESETTER_COMMAND_ENCODER_CORE_MACROS_SVH
`define PHOTOTYPESETTER_COMMAND_ENCODER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Check that prop holds at every rising clock edge outside reset
`define PCE_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("phototypesetter_command_encoder_core: assertion failed");

// Check that cond never holds outside reset
`define PCE_ASSERT_NEVER(lbl, clk, rst_n, cond) `PCE_ASSERT(lbl, clk, rst_n, !(cond))

`else

`define PCE_ASSERT(lbl, clk, rst_n, prop)
`define PCE_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

// ===== hw/rtl/pce_pkg.sv =====
// ----------------------------------------------------------------------------
// pce_pkg
// Command codes, control byte codes, widths and the descriptor type shared by
// the execute stage and the result emitter.
// ----------------------------------------------------------------------------
package pce_pkg;

    // Field and state widths
    localparam int VAL_W  = 16;
    localparam int CMD_W  = 4;
    localparam int RES_W  = 11;
    localparam int HPOS_W = 14;
    localparam int VPOS_W = 15;
    localparam int MAG_W  = 15;

    // Resolution after reset and the page limits it gives
    localparam int RES_RST  = 432;
    localparam logic [HPOS_W-1:0] HMAX_RST = HPOS_W'(46 * (RES_RST / 6));
    localparam logic [VPOS_W-1:0] VMAX_RST = VPOS_W'(15 * RES_RST);

    // Reciprocal for division by 3 of values below 2**17
    localparam logic [15:0] RECIP3_M  = 16'd43691;
    localparam int          RECIP3_SH = 17;

    // Input commands
    localparam logic [CMD_W-1:0] CMD_H_ABS = 4'd0;
    localparam logic [CMD_W-1:0] CMD_H_REL = 4'd1;
    localparam logic [CMD_W-1:0] CMD_V_ABS = 4'd2;
    localparam logic [CMD_W-1:0] CMD_V_REL = 4'd3;
    localparam logic [CMD_W-1:0] CMD_FONT  = 4'd4;
    localparam logic [CMD_W-1:0] CMD_SIZE  = 4'd5;
    localparam logic [CMD_W-1:0] CMD_GLYPH = 4'd6;
    localparam logic [CMD_W-1:0] CMD_INIT  = 4'd7;
    localparam logic [CMD_W-1:0] CMD_STOP  = 4'd8;

    // Typesetter control bytes
    localparam logic [7:0] CODE_INIT      = 8'o100;
    localparam logic [7:0] CODE_RAIL_LO   = 8'o101;
    localparam logic [7:0] CODE_RAIL_HI   = 8'o102;
    localparam logic [7:0] CODE_MAG_HI    = 8'o103;
    localparam logic [7:0] CODE_MAG_LO    = 8'o104;
    localparam logic [7:0] CODE_CASE_LO   = 8'o105;
    localparam logic [7:0] CODE_CASE_HI   = 8'o106;
    localparam logic [7:0] CODE_H_FWD     = 8'o107;
    localparam logic [7:0] CODE_H_BACK    = 8'o110;
    localparam logic [7:0] CODE_STOP      = 8'o111;
    localparam logic [7:0] CODE_V_DOWN    = 8'o112;
    localparam logic [7:0] CODE_V_UP      = 8'o114;
    localparam logic [7:0] CODE_SIZE      = 8'o120;
    localparam logic [7:0] CODE_V_UNIT    = 8'o140;
    localparam logic [7:0] CODE_H_UNIT    = 8'o200;
    localparam logic [7:0] CODE_STOP_TAIL = 8'o101;
    localparam logic [7:0] STOP_TAIL_REP  = 8'd8;

    // Chunk lengths of horizontal and vertical motion
    localparam logic [7:0] H_CHUNK = 8'd127;
    localparam logic [7:0] V_CHUNK = 8'd31;

    // Rail, magnifier and case selections
    localparam logic [1:0] SEL_UNKNOWN = 2'd0;
    localparam logic [1:0] SEL_LOWER   = 2'd1;
    localparam logic [1:0] SEL_UPPER   = 2'd2;

    typedef enum logic [1:0] {
        MOT_NONE,
        MOT_H,
        MOT_V
    } pce_mot_t;

    // One command's results: up to two leading bytes, a motion, a trailing byte
    typedef struct packed {
        logic             b0_vld;
        logic [7:0]       b0_code;
        logic             b1_vld;
        logic [7:0]       b1_code;
        pce_mot_t         mot_kind;
        logic [MAG_W-1:0] mot_mag;
        logic             b2_vld;
        logic [7:0]       b2_code;
        logic             b2_rep8;
    } pce_desc_t;

    // Size control byte for a size index 1-16
    function automatic logic [7:0] size_code(input logic [4:0] idx);
        logic [7:0] low;
        unique case (idx)
            5'd1:    low = 8'o10;
            5'd2:    low = 8'o00;
            5'd3:    low = 8'o01;
            5'd4:    low = 8'o07;
            5'd5:    low = 8'o02;
            5'd6:    low = 8'o03;
            5'd7:    low = 8'o04;
            5'd8:    low = 8'o05;
            5'd9:    low = 8'o11;
            5'd10:   low = 8'o06;
            5'd11:   low = 8'o12;
            5'd12:   low = 8'o13;
            5'd13:   low = 8'o14;
            5'd14:   low = 8'o15;
            5'd15:   low = 8'o16;
            5'd16:   low = 8'o17;
            default: low = 8'o00;
        endcase
        return CODE_SIZE | low;
    endfunction

endpackage

// ===== hw/rtl/phototypesetter_command_encoder_core.sv =====
// ----------------------------------------------------------------------------
// phototypesetter_command_encoder_core
// Encodes position, font, size and glyph commands into typesetter bytes.
// ----------------------------------------------------------------------------
// Commands enter on the s_ stream (cmd in tuser, value in tdata) and pass an
// input register, an execute stage that updates the typesetter state and
// builds a result descriptor, and the emitter that sends one control byte
// with its repeat count per cycle on the m_ stream while m_tready is high,
// tlast on the final byte of a command. The emitter's single output register
// sets the rate: a command with k results (0 to 5) sends k words through it,
// so commands with at most one result stream at one per cycle while m_tready
// is high. Commands pass the input, descriptor and output registers. The user
// must write the resolution register (cfg_ channel, always ready) only while
// the block is idle (not enforced); it takes effect for the next accepted command.
`include "phototypesetter_command_encoder_core_macros.svh"

module phototypesetter_command_encoder_core
    import pce_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [RES_W-1:0] cfg_data,   // resolution
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [15:0]      s_tdata,    // [15:0] value
    input  logic [CMD_W-1:0] s_tuser,    // [3:0] cmd
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [15:0]      m_tdata,    // [7:0] code, [15:8] repeat_res
    output logic             m_tlast
);

    logic      desc_valid;
    logic      desc_ready;
    pce_desc_t desc;
    logic      m_rep_ok;

    assign cfg_ready = 1'b1;

    // Execute stage: state, page limits, descriptor
    pce_exec u_exec (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tuser    (s_tuser),
        .s_tdata    (s_tdata),
        .desc_valid (desc_valid),
        .desc_ready (desc_ready),
        .desc       (desc)
    );

    // Emitter: chunk split and output register
    pce_emit u_emit (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .desc_valid (desc_valid),
        .desc_ready (desc_ready),
        .desc       (desc),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

    // Codes that may carry a repeat count above one
    assign m_rep_ok = (m_tdata[7:0] == CODE_H_UNIT) || (m_tdata[7:0] == CODE_V_UNIT) ||
                      (m_tdata[7:0] == CODE_STOP_TAIL);

    // A stalled descriptor stays put until the emitter drains it
    `PCE_ASSERT(a_desc_hold, aclk, aresetn, desc_valid && !desc_ready |=> desc_valid && $stable(desc))

    // Input back-pressure only comes from a stalled descriptor
    `PCE_ASSERT(a_ready_cause, aclk, aresetn, !s_tready |-> desc_valid && !desc_ready)

    // Every word is sent at least once
    `PCE_ASSERT_NEVER(a_rep_nonzero, aclk, aresetn, m_tvalid && m_tdata[15:8] == 8'd0)

    // Only motion chunks and the stop tail repeat
    `PCE_ASSERT(a_rep_codes, aclk, aresetn, m_tvalid && m_tdata[15:8] != 8'd1 |-> m_rep_ok)

endmodule

// ===== hw/rtl/pce_exec.sv =====
// ----------------------------------------------------------------------------
// pce_exec
// Input register, typesetter state, page limits and the execute logic that
// turns one command into a result descriptor.
// ----------------------------------------------------------------------------
module pce_exec
    import pce_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_valid,
    input  logic [RES_W-1:0] cfg_data,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [CMD_W-1:0] s_tuser,
    input  logic [VAL_W-1:0] s_tdata,
    output logic             desc_valid,
    input  logic             desc_ready,
    output pce_desc_t        desc
);

    logic             in_valid_reg;
    logic [CMD_W-1:0] in_cmd_reg;
    logic [VAL_W-1:0] in_value_reg;
    logic             in_adv;

    logic [HPOS_W-1:0] hmax_reg;
    logic [VPOS_W-1:0] vmax_reg;
    logic [20:0]       cfg_prod;
    logic [8:0]        cfg_div6;

    logic [VAL_W-1:0]  wanted_h_reg, wanted_h_next;
    logic [HPOS_W-1:0] sent_h_reg, sent_h_next;
    logic [VPOS_W-1:0] vert_pos_reg, vert_pos_next;
    logic              h_backward_reg, h_backward_next;
    logic              v_upward_reg, v_upward_next;
    logic [1:0]        rail_sel_reg, rail_sel_next;
    logic [1:0]        mag_sel_reg, mag_sel_next;
    logic [1:0]        case_sel_reg, case_sel_next;
    logic [4:0]        size_sel_reg, size_sel_next;

    logic              desc_valid_reg;
    pce_desc_t         desc_reg, desc_next;
    logic              desc_any;

    logic [16:0]       hrel_sum;
    logic [VAL_W-1:0]  hrel_sat;
    logic [17:0]       v_sum;
    logic [VPOS_W-1:0] v_tgt;
    logic [15:0]       v_dist;
    logic              v_up;
    logic [MAG_W-1:0]  v_mag;
    logic [15:0]       v_inc;
    logic [31:0]       v_prod;
    logic [VPOS_W-1:0] v_third;
    logic [VPOS_W-1:0] v_round;
    logic [HPOS_W-1:0] h_tgt;
    logic [14:0]       h_dist;
    logic              h_back;
    logic [HPOS_W-1:0] h_mag;
    logic [1:0]        font_rail;
    logic [1:0]        font_mag;
    logic [1:0]        glyph_case;
    logic [7:0]        glyph_code;

    // Advance the input register into the descriptor stage when it is free
    assign in_adv     = in_valid_reg && (!desc_valid_reg || desc_ready);
    assign s_tready   = !in_valid_reg || in_adv;
    assign desc_valid = desc_valid_reg;
    assign desc       = desc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_cmd_reg   <= s_tuser;
            in_value_reg <= s_tdata;
        end
    end

    // Page limits from the resolution: width 46*(res/6), length 15*res
    assign cfg_prod = 21'(cfg_data) * 21'd683;
    assign cfg_div6 = cfg_prod[20:12];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hmax_reg <= HMAX_RST;
            vmax_reg <= VMAX_RST;
        end else if (cfg_valid) begin
            hmax_reg <= HPOS_W'(cfg_div6) * HPOS_W'(46);
            vmax_reg <= VPOS_W'(cfg_data) * VPOS_W'(15);
        end
    end

    // Saturate the relative horizontal sum to 16 bits signed
    assign hrel_sum = {wanted_h_reg[15], wanted_h_reg} + {in_value_reg[15], in_value_reg};
    always_comb begin
        if (hrel_sum[16] != hrel_sum[15]) begin
            hrel_sat = hrel_sum[16] ? 16'h8000 : 16'h7fff;
        end else begin
            hrel_sat = hrel_sum[15:0];
        end
    end

    // Clamp the vertical target into 0..VMAX and round the new position
    assign v_sum = (in_cmd_reg == CMD_V_ABS) ? {{2{in_value_reg[15]}}, in_value_reg}
                 : ({3'b000, vert_pos_reg} + {{2{in_value_reg[15]}}, in_value_reg});
    always_comb begin
        if (v_sum[17]) begin
            v_tgt = '0;
        end else if (v_sum[16:0] > {2'b00, vmax_reg}) begin
            v_tgt = vmax_reg;
        end else begin
            v_tgt = v_sum[14:0];
        end
    end
    assign v_dist  = {1'b0, v_tgt} - {1'b0, vert_pos_reg};
    assign v_up    = v_dist[15];
    assign v_mag   = MAG_W'(v_up ? (16'd0 - v_dist) : v_dist);
    assign v_inc   = {1'b0, v_tgt} + 16'd1;
    assign v_prod  = 32'(v_inc) * 32'(RECIP3_M);
    assign v_third = v_prod[RECIP3_SH +: VPOS_W];
    assign v_round = v_third * VPOS_W'(3);

    // Clamp the wanted horizontal position into 0..HMAX for a flush
    always_comb begin
        if (wanted_h_reg[15]) begin
            h_tgt = '0;
        end else if (wanted_h_reg[14:0] > {1'b0, hmax_reg}) begin
            h_tgt = hmax_reg;
        end else begin
            h_tgt = wanted_h_reg[13:0];
        end
    end
    assign h_dist = {1'b0, h_tgt} - {1'b0, sent_h_reg};
    assign h_back = h_dist[14];
    assign h_mag  = HPOS_W'(h_back ? (15'd0 - h_dist) : h_dist);

    // Font and glyph selections
    assign font_rail  = in_value_reg[0] ? SEL_LOWER : SEL_UPPER;
    assign font_mag   = (in_value_reg >= 16'd3) ? SEL_UPPER : SEL_LOWER;
    assign glyph_case = (in_value_reg >= 16'd64) ? SEL_UPPER : SEL_LOWER;
    assign glyph_code = (glyph_case == SEL_UPPER) ? (in_value_reg[7:0] - 8'd64)
                      : in_value_reg[7:0];

    // Decode the command into next state and a descriptor
    always_comb begin
        wanted_h_next   = wanted_h_reg;
        sent_h_next     = sent_h_reg;
        vert_pos_next   = vert_pos_reg;
        h_backward_next = h_backward_reg;
        v_upward_next   = v_upward_reg;
        rail_sel_next   = rail_sel_reg;
        mag_sel_next    = mag_sel_reg;
        case_sel_next   = case_sel_reg;
        size_sel_next   = size_sel_reg;
        desc_next       = '0;
        unique case (in_cmd_reg)
            CMD_H_ABS: begin
                wanted_h_next = in_value_reg;
            end
            CMD_H_REL: begin
                wanted_h_next = hrel_sat;
            end
            CMD_V_ABS, CMD_V_REL: begin
                vert_pos_next      = v_round;
                v_upward_next      = v_up;
                desc_next.b0_vld   = (v_up != v_upward_reg);
                desc_next.b0_code  = v_up ? CODE_V_UP : CODE_V_DOWN;
                desc_next.mot_kind = MOT_V;
                desc_next.mot_mag  = v_mag;
            end
            CMD_FONT: begin
                if (in_value_reg != 16'd0 && in_value_reg <= 16'd4) begin
                    rail_sel_next     = font_rail;
                    mag_sel_next      = font_mag;
                    desc_next.b0_vld  = (rail_sel_reg != font_rail);
                    desc_next.b0_code = (font_rail == SEL_UPPER) ? CODE_RAIL_HI
                                      : CODE_RAIL_LO;
                    desc_next.b1_vld  = (mag_sel_reg != font_mag);
                    desc_next.b1_code = (font_mag == SEL_UPPER) ? CODE_MAG_HI
                                      : CODE_MAG_LO;
                end
            end
            CMD_SIZE: begin
                if (in_value_reg != 16'd0 && in_value_reg <= 16'd16 &&
                    in_value_reg[4:0] != size_sel_reg) begin
                    size_sel_next     = in_value_reg[4:0];
                    desc_next.b0_vld  = 1'b1;
                    desc_next.b0_code = size_code(in_value_reg[4:0]);
                end
            end
            CMD_GLYPH: begin
                if (in_value_reg != 16'd0 && in_value_reg <= 16'd255) begin
                    case_sel_next      = glyph_case;
                    sent_h_next        = h_tgt;
                    h_backward_next    = h_back;
                    desc_next.b0_vld   = (case_sel_reg != glyph_case);
                    desc_next.b0_code  = (glyph_case == SEL_UPPER) ? CODE_CASE_HI
                                       : CODE_CASE_LO;
                    desc_next.b1_vld   = (h_back != h_backward_reg);
                    desc_next.b1_code  = h_back ? CODE_H_BACK : CODE_H_FWD;
                    desc_next.mot_kind = MOT_H;
                    desc_next.mot_mag  = {1'b0, h_mag};
                    desc_next.b2_vld   = 1'b1;
                    desc_next.b2_code  = glyph_code;
                end
            end
            CMD_INIT: begin
                wanted_h_next     = '0;
                sent_h_next       = '0;
                vert_pos_next     = '0;
                h_backward_next   = 1'b0;
                v_upward_next     = 1'b0;
                rail_sel_next     = SEL_LOWER;
                mag_sel_next      = SEL_LOWER;
                case_sel_next     = SEL_LOWER;
                desc_next.b0_vld  = 1'b1;
                desc_next.b0_code = CODE_INIT;
            end
            CMD_STOP: begin
                desc_next.b0_vld  = 1'b1;
                desc_next.b0_code = CODE_INIT;
                desc_next.b1_vld  = 1'b1;
                desc_next.b1_code = CODE_STOP;
                desc_next.b2_vld  = 1'b1;
                desc_next.b2_code = CODE_STOP_TAIL;
                desc_next.b2_rep8 = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign desc_any = desc_next.b0_vld || desc_next.b1_vld || desc_next.b2_vld ||
                      (desc_next.mot_kind != MOT_NONE);

    // Commit state on advance
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wanted_h_reg   <= '0;
            sent_h_reg     <= '0;
            vert_pos_reg   <= '0;
            h_backward_reg <= 1'b0;
            v_upward_reg   <= 1'b0;
            rail_sel_reg   <= SEL_UNKNOWN;
            mag_sel_reg    <= SEL_UNKNOWN;
            case_sel_reg   <= SEL_UNKNOWN;
            size_sel_reg   <= '0;
        end else if (in_adv) begin
            wanted_h_reg   <= wanted_h_next;
            sent_h_reg     <= sent_h_next;
            vert_pos_reg   <= vert_pos_next;
            h_backward_reg <= h_backward_next;
            v_upward_reg   <= v_upward_next;
            rail_sel_reg   <= rail_sel_next;
            mag_sel_reg    <= mag_sel_next;
            case_sel_reg   <= case_sel_next;
            size_sel_reg   <= size_sel_next;
        end
    end

    // Hold the descriptor until the emitter drains it; drop empty ones
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            desc_valid_reg <= 1'b0;
        end else if (in_adv) begin
            desc_valid_reg <= desc_any;
        end else if (desc_ready) begin
            desc_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_adv) begin
            desc_reg <= desc_next;
        end
    end

endmodule

// ===== hw/rtl/pce_emit.sv =====
// ----------------------------------------------------------------------------
// pce_emit
// Splits the motion of a descriptor into chunks and sends the descriptor's
// results one word per cycle through the output register while m_tready is high.
// ----------------------------------------------------------------------------
module pce_emit
    import pce_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        desc_valid,
    output logic        desc_ready,
    input  pce_desc_t   desc,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,
    output logic        m_tlast
);

    localparam int SLOT_B0    = 0;
    localparam int SLOT_B1    = 1;
    localparam int SLOT_FULL0 = 2;
    localparam int SLOT_FULL1 = 3;
    localparam int SLOT_PART  = 4;
    localparam int SLOT_B2    = 5;
    localparam int NSLOT      = 6;

    logic [NSLOT-1:0] done_reg, done_next;
    logic             m_valid_reg;
    logic [7:0]       code_reg, code_next;
    logic [7:0]       rep_reg, rep_next;
    logic             last_reg;

    logic [28:0] h_prod;
    logic [7:0]  h_q;
    logic [6:0]  h_r;
    logic [15:0] v_x;
    logic [31:0] v_prod_u;
    logic [31:0] v_prod_q;
    logic [14:0] v_units;
    logic [8:0]  v_q;
    logic [4:0]  v_r;

    logic [8:0]  q_sel;
    logic [6:0]  r_sel;
    logic [7:0]  unit_base;
    logic [7:0]  chunk;
    logic [7:0]  full0_cnt;
    logic [7:0]  full1_cnt;
    logic [7:0]  part_code;

    logic [NSLOT-1:0] present;
    logic [NSLOT-1:0] rem;
    logic [NSLOT-1:0] sel;
    logic             sel_last;
    logic             out_free;
    logic             load;

    // Horizontal split: q = mag/127 by reciprocal, r = mag - 127*q
    assign h_prod = 29'(desc.mot_mag[HPOS_W-1:0]) * 29'd16514;
    assign h_q    = h_prod[28:21];
    assign h_r    = 7'(desc.mot_mag[HPOS_W-1:0] - 14'(h_q) * 14'd127);

    // Vertical split: units = (mag+1)/3, q = (mag+1)/93, r = units - 31*q
    assign v_x      = {1'b0, desc.mot_mag} + 16'd1;
    assign v_prod_u = 32'(v_x) * 32'(RECIP3_M);
    assign v_prod_q = 32'(v_x) * 32'd45101;
    assign v_units  = v_prod_u[RECIP3_SH +: 15];
    assign v_q      = v_prod_q[30:22];
    assign v_r      = 5'(v_units - 15'(v_q) * 15'd31);

    always_comb begin
        unique case (desc.mot_kind)
            MOT_H: begin
                q_sel     = {1'b0, h_q};
                r_sel     = h_r;
                unit_base = CODE_H_UNIT;
                chunk     = H_CHUNK;
            end
            MOT_V: begin
                q_sel     = v_q;
                r_sel     = {2'b00, v_r};
                unit_base = CODE_V_UNIT;
                chunk     = V_CHUNK;
            end
            default: begin
                q_sel     = '0;
                r_sel     = '0;
                unit_base = CODE_H_UNIT;
                chunk     = H_CHUNK;
            end
        endcase
    end

    // More than 255 full chunks go out as two words
    assign full0_cnt = (q_sel > 9'd255) ? 8'd255 : q_sel[7:0];
    assign full1_cnt = 8'(q_sel - 9'd255);
    assign part_code = unit_base | (chunk - {1'b0, r_sel});

    // Pick the lowest pending slot
    always_comb begin
        present             = '0;
        present[SLOT_B0]    = desc.b0_vld;
        present[SLOT_B1]    = desc.b1_vld;
        present[SLOT_FULL0] = (q_sel != 9'd0);
        present[SLOT_FULL1] = (q_sel > 9'd255);
        present[SLOT_PART]  = (r_sel != 7'd0);
        present[SLOT_B2]    = desc.b2_vld;
    end
    assign rem      = present & ~done_reg;
    assign sel      = rem & (~rem + NSLOT'(1));
    assign sel_last = ((rem & ~sel) == '0);

    always_comb begin
        priority if (sel[SLOT_B0]) begin
            code_next = desc.b0_code;
            rep_next  = 8'd1;
        end else if (sel[SLOT_B1]) begin
            code_next = desc.b1_code;
            rep_next  = 8'd1;
        end else if (sel[SLOT_FULL0]) begin
            code_next = unit_base;
            rep_next  = full0_cnt;
        end else if (sel[SLOT_FULL1]) begin
            code_next = unit_base;
            rep_next  = full1_cnt;
        end else if (sel[SLOT_PART]) begin
            code_next = part_code;
            rep_next  = 8'd1;
        end else begin
            code_next = desc.b2_code;
            rep_next  = desc.b2_rep8 ? STOP_TAIL_REP : 8'd1;
        end
    end

    // Release the descriptor after its last word or when it has none
    assign out_free   = !m_valid_reg || m_tready;
    assign load       = desc_valid && (rem != '0) && out_free;
    assign desc_ready = desc_valid && ((rem == '0) || (out_free && sel_last));

    always_comb begin
        if (desc_ready) begin
            done_next = '0;
        end else if (load) begin
            done_next = done_reg | sel;
        end else begin
            done_next = done_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            done_reg <= done_next;
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            code_reg <= code_next;
            rep_reg  <= rep_next;
            last_reg <= sel_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {rep_reg, code_reg};
    assign m_tlast  = last_reg;

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: phototypesetter command encoder testbench
// Drives command words through the s_ stream and checks every control byte on
// the m_ stream against a predictor of the typesetter state. It covers the
// directed corner commands, several page resolutions, random traffic with
// source gaps and sink stalls, and a long sink hold-off.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pce_pkg::*;

    // Unused command codes, which the block drops
    localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 4'd9;
    localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 4'd15;
    localparam int IDLE_TAIL = 16;
    localparam int HOLD_OFF_CYCLES = 300;

    typedef struct packed {
        logic [7:0] code;
        logic [7:0] rep;
        logic       last;
    } ctl_byte_t;

    logic             aclk = 1'b0;
    logic             aresetn;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [RES_W-1:0] cfg_data;
    logic             s_tvalid;
    logic             s_tready;
    logic [15:0]      s_tdata;    // [15:0] value
    logic [CMD_W-1:0] s_tuser;    // [3:0] cmd
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [15:0]      m_tdata;    // [7:0] code, [15:8] repeat_res
    logic             m_tlast;

    // Expected control bytes, oldest first, and the bytes of one command
    ctl_byte_t expected_bytes[$];
    ctl_byte_t cmd_bytes[$];
    ctl_byte_t got;
    int        mismatch_cnt = 0;
    int        src_idle_pct = 0;
    int        sink_stall_pct = 0;
    int        hold_left = 0;

    // Predicted typesetter state
    int         res_now;
    int         want_h;
    int         sent_h;
    int         vpos;
    bit         h_back;
    bit         v_up;
    logic [1:0] rail;
    logic [1:0] mag;
    logic [1:0] cse;
    int         size_now;

    phototypesetter_command_encoder_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #3_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic void emit_byte(input logic [7:0] code, input int rep);
        ctl_byte_t b;
        b.code = code;
        b.rep  = rep[7:0];
        b.last = 1'b0;
        cmd_bytes.push_back(b);
    endfunction

    // Full chunks with a repeat count of at most 255, then the remainder
    function automatic void emit_motion(input logic [7:0] base, input int chunk,
                                        input int units);
        int q;
        int r;
        int c;
        q = units / chunk;
        r = units % chunk;
        while (q > 0) begin
            c = (q > 255) ? 255 : q;
            emit_byte(base, c);
            q -= c;
        end
        if (r != 0) emit_byte(base | 8'(chunk - r), 1);
    endfunction

    function automatic void flush_horiz();
        int hmax;
        int t;
        int n;
        bit back;
        hmax = 46 * (res_now / 6);
        t = want_h;
        if (t > hmax) t = hmax;
        if (t < 0) t = 0;
        n = t - sent_h;
        back = (n < 0);
        if (back != h_back) begin
            h_back = back;
            emit_byte(back ? CODE_H_BACK : CODE_H_FWD, 1);
        end
        emit_motion(CODE_H_UNIT, int'(H_CHUNK), (n < 0) ? -n : n);
        sent_h = t & 16'h3FFF;
    endfunction

    // Clamp to the page, round the position to thirds, send the motion
    function automatic void move_vert(input int step);
        int vmax;
        int v;
        bit up;
        vmax = 15 * res_now;
        v = vpos;
        if (v + step > vmax) step = vmax - v;
        if (v + step < 0) step = -v;
        v += step;
        v = ((v + 1) / 3) * 3;
        vpos = v & 16'h7FFF;
        up = (step < 0);
        if (up != v_up) begin
            v_up = up;
            emit_byte(up ? CODE_V_UP : CODE_V_DOWN, 1);
        end
        emit_motion(CODE_V_UNIT, int'(V_CHUNK), (((step < 0) ? -step : step) + 1) / 3);
    endfunction

    function automatic logic [7:0] size_byte(input int idx);
        logic [7:0] low;
        case (idx)
            1:       low = 8'o10;
            3:       low = 8'o01;
            4:       low = 8'o07;
            5:       low = 8'o02;
            6:       low = 8'o03;
            7:       low = 8'o04;
            8:       low = 8'o05;
            9:       low = 8'o11;
            10:      low = 8'o06;
            11:      low = 8'o12;
            12:      low = 8'o13;
            13:      low = 8'o14;
            14:      low = 8'o15;
            15:      low = 8'o16;
            16:      low = 8'o17;
            default: low = 8'o00;
        endcase
        return CODE_SIZE | low;
    endfunction

    function automatic void reset_state();
        res_now  = RES_RST;
        want_h   = 0;
        sent_h   = 0;
        vpos     = 0;
        h_back   = 1'b0;
        v_up     = 1'b0;
        rail     = SEL_UNKNOWN;
        mag      = SEL_UNKNOWN;
        cse      = SEL_UNKNOWN;
        size_now = 0;
    endfunction

    // Work out the bytes of one command and queue them as expected
    function automatic void encode_cmd(input logic [CMD_W-1:0] cmd, input logic [15:0] raw);
        int         val;
        int         s;
        logic [7:0] code;
        logic [1:0] rl;
        logic [1:0] mg;
        logic [1:0] want;
        val = int'($signed(raw));
        cmd_bytes.delete();
        case (cmd)
            CMD_H_ABS: want_h = val;
            CMD_H_REL: begin
                s = want_h + val;
                if (s > 32767) s = 32767;
                if (s < -32768) s = -32768;
                want_h = s;
            end
            CMD_V_ABS: move_vert(val - vpos);
            CMD_V_REL: move_vert(val);
            CMD_FONT: begin
                if (val >= 1 && val <= 4) begin
                    rl = (val == 2 || val == 4) ? SEL_UPPER : SEL_LOWER;
                    mg = (val >= 3) ? SEL_UPPER : SEL_LOWER;
                    if (rail != rl) begin
                        rail = rl;
                        emit_byte((rl == SEL_UPPER) ? CODE_RAIL_HI : CODE_RAIL_LO, 1);
                    end
                    if (mag != mg) begin
                        mag = mg;
                        emit_byte((mg == SEL_UPPER) ? CODE_MAG_HI : CODE_MAG_LO, 1);
                    end
                end
            end
            CMD_SIZE: begin
                if (val >= 1 && val <= 16 && val != size_now) begin
                    emit_byte(size_byte(val), 1);
                    size_now = val;
                end
            end
            CMD_GLYPH: begin
                if (val >= 1 && val <= 255) begin
                    code = val[7:0];
                    want = (val < 64) ? SEL_LOWER : SEL_UPPER;
                    if (want == SEL_UPPER) code = code - 8'd64;
                    if (cse != want) begin
                        cse = want;
                        emit_byte((want == SEL_UPPER) ? CODE_CASE_HI : CODE_CASE_LO, 1);
                    end
                    flush_horiz();
                    emit_byte(code, 1);
                end
            end
            CMD_INIT: begin
                emit_byte(CODE_INIT, 1);
                want_h = 0;
                sent_h = 0;
                vpos   = 0;
                h_back = 1'b0;
                v_up   = 1'b0;
                rail   = SEL_LOWER;
                mag    = SEL_LOWER;
                cse    = SEL_LOWER;
            end
            CMD_STOP: begin
                emit_byte(CODE_INIT, 1);
                emit_byte(CODE_STOP, 1);
                emit_byte(CODE_STOP_TAIL, int'(STOP_TAIL_REP));
            end
            default: ;
        endcase
        if (cmd_bytes.size() > 0) cmd_bytes[cmd_bytes.size() - 1].last = 1'b1;
        foreach (cmd_bytes[i]) expected_bytes.push_back(cmd_bytes[i]);
    endfunction

    // ------------------------------------------------------------------
    // Result checker and sink
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_bytes.size() == 0) begin
                $error("unexpected word: code %0h rep %0d last %0b",
                       m_tdata[7:0], m_tdata[15:8], m_tlast);
                mismatch_cnt++;
            end else begin
                got = expected_bytes.pop_front();
                if (m_tdata[7:0] !== got.code) begin
                    $error("code: expected %0o, got %0o", got.code, m_tdata[7:0]);
                    mismatch_cnt++;
                end
                if (m_tdata[15:8] !== got.rep) begin
                    $error("repeat_res: expected %0d, got %0d", got.rep, m_tdata[15:8]);
                    mismatch_cnt++;
                end
                if (m_tlast !== got.last) begin
                    $error("last: expected %0b, got %0b", got.last, m_tlast);
                    mismatch_cnt++;
                end
            end
        end
        // hold off for a counted stretch, else stall at random
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else begin
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [15:0] value);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= value;
        do @(posedge aclk); while (!s_tready);
        encode_cmd(cmd, value);
    endtask

    // Stop sending until every expected word has come, then let the pipe empty
    task automatic drain_pause();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_bytes.size() != 0);
        repeat (IDLE_TAIL) @(posedge aclk);
    endtask

    task automatic write_resolution(input logic [RES_W-1:0] res);
        cfg_valid <= 1'b1;
        cfg_data  <= res;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        res_now = int'(res);
    endtask

    // Mostly well-formed commands with random content, some noise
    task automatic send_random_cmd();
        int               w;
        logic [CMD_W-1:0] cmd;
        logic [15:0]      value;
        w = $urandom_range(99);
        value = 16'($urandom);
        if (w < 4) begin
            cmd = 4'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
        end else if (w < 16) begin
            cmd = CMD_H_ABS;
            if ($urandom_range(3) != 0) value = 16'($urandom_range(16000));
        end else if (w < 30) begin
            cmd = CMD_H_REL;
            if ($urandom_range(3) != 0) value = 16'($urandom_range(600) - 300);
        end else if (w < 40) begin
            cmd = CMD_V_ABS;
            if ($urandom_range(3) != 0) value = 16'($urandom_range(7000));
        end else if (w < 54) begin
            cmd = CMD_V_REL;
            if ($urandom_range(3) != 0) value = 16'($urandom_range(800) - 400);
        end else if (w < 62) begin
            cmd = CMD_FONT;
            if ($urandom_range(9) != 0) value = 16'($urandom_range(1, 4));
        end else if (w < 70) begin
            cmd = CMD_SIZE;
            if ($urandom_range(6) != 0) value = 16'($urandom_range(1, 16));
        end else if (w < 96) begin
            cmd = CMD_GLYPH;
            if ($urandom_range(9) != 0) value = 16'($urandom_range(1, 255));
        end else if (w < 98) begin
            cmd = CMD_INIT;
        end else begin
            cmd = CMD_STOP;
        end
        send_cmd(cmd, value);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed_corners();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        // glyph and font with no selection known yet
        send_cmd(CMD_GLYPH, 16'd33);
        send_cmd(CMD_FONT, 16'd4);
        send_cmd(CMD_FONT, 16'd0);
        send_cmd(CMD_FONT, 16'd5);
        send_cmd(CMD_SIZE, 16'd1);
        send_cmd(CMD_SIZE, 16'd1);
        send_cmd(CMD_SIZE, 16'd16);
        send_cmd(CMD_SIZE, 16'd17);
        send_cmd(CMD_SIZE, 16'hFFFF);
        send_cmd(CMD_INIT, 16'd0);
        send_cmd(CMD_FONT, 16'd1);
        // horizontal motion forward, then back with saturation
        send_cmd(CMD_H_ABS, 16'd1000);
        send_cmd(CMD_GLYPH, 16'd64);
        send_cmd(CMD_H_ABS, 16'hFF9C);
        send_cmd(CMD_H_REL, 16'h8000);
        send_cmd(CMD_GLYPH, 16'd1);
        send_cmd(CMD_H_ABS, 16'h7FFF);
        send_cmd(CMD_H_REL, 16'h7FFF);
        send_cmd(CMD_GLYPH, 16'd255);
        send_cmd(CMD_GLYPH, 16'd0);
        send_cmd(CMD_GLYPH, 16'd256);
        send_cmd(CMD_GLYPH, 16'hFFFF);
        // vertical clamp at both page edges, zero move, rounding
        send_cmd(CMD_V_ABS, 16'h7FFF);
        send_cmd(CMD_V_REL, 16'h8000);
        send_cmd(CMD_V_REL, 16'd0);
        send_cmd(CMD_V_REL, 16'd2);
        send_cmd(CMD_UNUSED_LO, 16'h5A5A);
        send_cmd(CMD_UNUSED_HI, 16'hA5A5);
        send_cmd(CMD_STOP, 16'd0);
    endtask

    task automatic test_resolution_sweep();
        logic [RES_W-1:0] res_list [6];
        res_list = '{11'd6, 11'd1200, 11'd2047, 11'd3, 11'd0, 11'd432};
        res_list[5] = 11'($urandom_range(6, 1200));
        src_idle_pct   = 10;
        sink_stall_pct = 10;
        foreach (res_list[i]) begin
            drain_pause();
            write_resolution(res_list[i]);
            send_cmd(CMD_INIT, 16'd0);
            send_cmd(CMD_V_ABS, 16'h7FFF);
            send_cmd(CMD_V_ABS, 16'd0);
            send_cmd(CMD_V_REL, 16'd1);
            send_cmd(CMD_H_ABS, 16'h7FFF);
            send_cmd(CMD_GLYPH, 16'd65);
            send_cmd(CMD_H_ABS, 16'hFFFB);
            send_cmd(CMD_GLYPH, 16'd66);
            send_cmd(CMD_STOP, 16'd0);
            repeat (1) send_random_cmd();
        end
    endtask

    task automatic test_random_traffic();
        int src_pct [4];
        int sink_pct [4];
        src_pct  = '{0, 45, 0, 25};
        sink_pct = '{0, 0, 45, 25};
        foreach (src_pct[i]) begin
            src_idle_pct   = src_pct[i];
            sink_stall_pct = sink_pct[i];
            repeat (6) send_random_cmd();
        end
    endtask

    task automatic test_sink_hold_off();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_left      = HOLD_OFF_CYCLES;
        // multi-byte commands fill the pipe while the sink holds off
        repeat (3) begin
            send_cmd(CMD_STOP, 16'd0);
            send_cmd(CMD_H_ABS, 16'($urandom_range(2000, 6000)));
            send_cmd(CMD_GLYPH, 16'($urandom_range(64, 255)));
            send_cmd(CMD_V_REL, 16'($urandom_range(1000, 3000)));
        end
        drain_pause();
        sink_stall_pct = 30;
        repeat (8) send_random_cmd();
    endtask

    initial begin
        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        reset_state();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_corners();
        test_resolution_sweep();
        test_random_traffic();
        test_sink_hold_off();

        drain_pause();
        if (mismatch_cnt == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
